FILE: sv/clcg_pkg.sv
// Shared types and fixed constants of the combined congruential generator.
package clcg_pkg;

    localparam int NUM_COMP   = 4;
    localparam int STATE_W    = 31;
    localparam int MULT_W     = 18;
    localparam int PROD_W     = STATE_W + MULT_W;
    localparam int FOLD_C_W   = 9;
    localparam int OUT_W      = 32;
    localparam int COMP_IDX_W = 2;

    typedef logic [STATE_W-1:0] state_word_t;

    // Component k sits at element [k]
    localparam logic [NUM_COMP-1:0][MULT_W-1:0] MULT_TAB = {
        18'd49689, 18'd138556, 18'd207707, 18'd45991
    };

    localparam logic [NUM_COMP-1:0][STATE_W-1:0] MOD_TAB = {
        31'd2147483323, 31'd2147483423, 31'd2147483543, 31'd2147483647
    };

    // 2^31 - modulus, used to fold the high part of a product back in
    localparam logic [NUM_COMP-1:0][FOLD_C_W-1:0] FOLD_TAB = {
        9'd325, 9'd225, 9'd105, 9'd1
    };

    // Request handed from the front queue to the back sequencer
    typedef struct packed {
        logic valid;
        logic restart;
    } clcg_req_t;

endpackage

FILE: sv/combined_lcg_uniform_generator.sv
// Per component the back end does one multiply, two folds, a scaling loop (longer at wider
// fractions) and one accumulate.
// A two-entry queue takes requests while the back end works; a waiting result stalls the
// back end in its output step, and the input once the queue is full.
// Reset: seeds and all four components return to one; queue and result are emptied.
module combined_lcg_uniform_generator #(
    parameter int FRACTION_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [30:0]                  cfg_data,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic                         restart,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic [31:0]                  uniform_fraction
);
    import clcg_pkg::*;

    logic [NUM_COMP-1:0][STATE_W-1:0] seed_reg;
    clcg_req_t                        req;
    logic                             pop;

    // Write seed registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_COMP; j++)
            begin
                seed_reg[j] <= STATE_W'(1);
            end
        end
        else if (cfg_we)
        begin
            seed_reg[cfg_index] <= cfg_data;
        end
    end

    clcg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .restart   (restart),
        .req       (req),
        .pop       (pop)
    );

    clcg_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .req              (req),
        .pop              (pop),
        .seeds            (seed_reg),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .uniform_fraction (uniform_fraction)
    );

endmodule

FILE: sv/clcg_front.sv
// Request front end: accepts restart requests into a two-entry queue.
module clcg_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                restart,
    output clcg_pkg::clcg_req_t req,
    input  logic                pop
);
    import clcg_pkg::*;

    localparam int DEPTH = 2;

    logic       entry_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;

    assign req_ready   = (count_reg != 2'(DEPTH));
    assign push        = req_valid && req_ready;
    assign req.valid   = (count_reg != 2'd0);
    assign req.restart = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the restart flag of an accepted request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= restart;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("request queue holds more than its depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("request popped from empty queue");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 2'd1)
        else $error("queue count did not drop after pop");

endmodule

FILE: sv/clcg_back.sv
// Back end: advances the four components through one shared multiplier,
// reducer and constant-modulus scaler, and adds or subtracts the scaled terms.
module clcg_back #(
    parameter int FRACTION_BITS = 32
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  clcg_pkg::clcg_req_t                        req,
    output logic                                       pop,
    input  logic [clcg_pkg::NUM_COMP-1:0][clcg_pkg::STATE_W-1:0] seeds,
    output logic                                       res_valid,
    input  logic                                       res_ready,
    output logic [clcg_pkg::OUT_W-1:0]                 uniform_fraction
);
    import clcg_pkg::*;

    localparam int Y_W  = STATE_W + FRACTION_BITS;
    localparam int HC_W = FRACTION_BITS + FOLD_C_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FOLD,
        S_FIX,
        S_DIV,
        S_ACC,
        S_OUT
    } back_state_t;

    back_state_t              state_reg;
    state_word_t              comp_reg [NUM_COMP];
    logic [COMP_IDX_W-1:0]    k_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [31:0]              fold_reg;
    logic [Y_W-1:0]           div_y_reg;
    logic [FRACTION_BITS-1:0] quo_reg;
    logic [FRACTION_BITS-1:0] acc_reg;
    logic                     res_valid_reg;
    logic [OUT_W-1:0]         result_reg;

    state_word_t              mod_k;
    logic [MULT_W-1:0]        mult_k;
    logic [FOLD_C_W-1:0]      fold_k;
    logic [PROD_W-1:0]        prod_next;
    logic [26:0]              hi_times_c;
    logic [31:0]              fold_next;
    logic [31:0]              fix_sum;
    logic [31:0]              fix_red;
    logic [FRACTION_BITS-1:0] div_hi;
    state_word_t              div_lo;
    logic [HC_W-1:0]          div_hi_c;
    logic [Y_W-1:0]           div_y_next;
    logic [OUT_W-1:0]         frac_out;
    logic                     out_free;

    assign mod_k  = MOD_TAB[k_reg];
    assign mult_k = MULT_TAB[k_reg];
    assign fold_k = FOLD_TAB[k_reg];

    assign pop       = (state_reg == S_IDLE) && req.valid;
    assign out_free  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign uniform_fraction = result_reg;

    // Multiply the selected component by its multiplier
    assign prod_next = PROD_W'(comp_reg[k_reg]) * PROD_W'(mult_k);

    // Fold the bits above 2^31 back in: 2^31 is congruent to the fold constant
    assign hi_times_c = 27'(prod_reg[PROD_W-1:STATE_W]) * 27'(fold_k);
    assign fold_next  = 32'(prod_reg[STATE_W-1:0]) + 32'(hi_times_c);

    // Second fold and final conditional subtract
    assign fix_sum = 32'(fold_reg[STATE_W-1:0]) + (fold_reg[31] ? 32'(fold_k) : 32'd0);
    assign fix_red = (fix_sum >= 32'(mod_k)) ? (fix_sum - 32'(mod_k)) : fix_sum;

    // Scale by 2^FRACTION_BITS / modulus: each fold moves hi*2^31 into the
    // quotient as hi*modulus and keeps hi*fold constant in the remainder
    assign div_hi     = div_y_reg[Y_W-1:STATE_W];
    assign div_lo     = div_y_reg[STATE_W-1:0];
    assign div_hi_c   = HC_W'(div_hi) * HC_W'(fold_k);
    assign div_y_next = Y_W'(div_hi_c) + Y_W'(div_lo);

    // Place the sum in the 32-bit result
    generate
        if (FRACTION_BITS <= OUT_W)
        begin : g_narrow
            assign frac_out = OUT_W'(acc_reg);
        end
        else
        begin : g_wide
            assign frac_out = acc_reg[FRACTION_BITS-1 -: OUT_W];
        end
    endgenerate

    // Sequencer, component state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
            for (int j = 0; j < NUM_COMP; j++)
            begin
                comp_reg[j] <= STATE_W'(1);
            end
        end
        else
        begin
            // Raise the result in the output step, drop it once taken
            if ((state_reg == S_OUT) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        if (req.restart)
                        begin
                            for (int j = 0; j < NUM_COMP; j++)
                            begin
                                comp_reg[j] <= seeds[j];
                            end
                        end
                        k_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_FOLD;
                end
                S_FOLD:
                begin
                    fold_reg  <= fold_next;
                    state_reg <= S_FIX;
                end
                S_FIX:
                begin
                    comp_reg[k_reg] <= fix_red[STATE_W-1:0];
                    div_y_reg       <= {fix_red[STATE_W-1:0], {FRACTION_BITS{1'b0}}};
                    quo_reg         <= '0;
                    state_reg       <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_hi != '0)
                    begin
                        div_y_reg <= div_y_next;
                        quo_reg   <= quo_reg + div_hi;
                    end
                    else
                    begin
                        // Remainder is below 2^31: at most one more modulus fits
                        if (div_lo >= mod_k)
                        begin
                            quo_reg <= quo_reg + FRACTION_BITS'(1);
                        end
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    // Odd components subtract, even ones add
                    acc_reg <= k_reg[0] ? (acc_reg - quo_reg) : (acc_reg + quo_reg);
                    if (k_reg == COMP_IDX_W'(NUM_COMP - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        result_reg <= frac_out;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_fold_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_hi != '0) |=> div_y_reg < $past(div_y_reg))
        else $error("scaling fold did not shrink the remainder");

    a_state_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIX |=> comp_reg[$past(k_reg)] < MOD_TAB[$past(k_reg)])
        else $error("advanced component not reduced below modulus");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside the output step");

endmodule
